### hw/rtl/ghp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gyro heading PID package
// Shared types, register codes, reset values, saturation and magnitude helpers.
// ----------------------------------------------------------------------------
package ghp_pkg;

  localparam int ANGLE_W = 32;
  localparam int RATE_W  = 16;
  localparam int GAIN_W  = 8;
  localparam int LIM_W   = 31;
  localparam int IDX_W   = 3;
  localparam int WIDE_W  = 48;

  typedef logic signed [ANGLE_W-1:0] q16_t;
  typedef logic signed [RATE_W-1:0]  rate_t;
  typedef logic [GAIN_W-1:0]         gain_t;
  typedef logic [LIM_W-1:0]          lim_t;
  typedef logic signed [WIDE_W-1:0]  wide_t;

  typedef enum logic [1:0] {
    FUNC_SAMPLE = 2'd0,
    FUNC_SET    = 2'd1,
    FUNC_TURN   = 2'd2,
    FUNC_HOLD   = 2'd3
  } func_t;

  typedef enum logic [IDX_W-1:0] {
    REG_ENABLE        = 3'd0,
    REG_ANGLE_GAIN    = 3'd1,
    REG_GAIN_P        = 3'd2,
    REG_GAIN_I        = 3'd3,
    REG_GAIN_D        = 3'd4,
    REG_TURN_LIMIT    = 3'd5,
    REG_WINDUP_LIMIT  = 3'd6,
    REG_HOLD_DEADBAND = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic         enable;
    logic [31:0]  angle_gain;
    gain_t        gain_p;
    gain_t        gain_i;
    gain_t        gain_d;
    lim_t         turn_limit;
    lim_t         windup_limit;
    lim_t         hold_deadband;
  } cfg_regs_t;

  localparam logic [31:0] ANGLE_GAIN_RST    = 32'd261888;
  localparam gain_t       GAIN_P_RST        = 8'd10;
  localparam gain_t       GAIN_I_RST        = 8'd5;
  localparam gain_t       GAIN_D_RST        = 8'd30;
  localparam lim_t        TURN_LIMIT_RST    = 31'd13107200;
  localparam lim_t        WINDUP_LIMIT_RST  = 31'd655360;
  localparam lim_t        HOLD_DEADBAND_RST = 31'd6554;

  localparam logic [32:0] ONE_DEGREE = 33'd65536;

  localparam wide_t SAT_MAX = 48'sd2147483647;
  localparam wide_t SAT_MIN = -48'sd2147483648;

  function automatic q16_t sat32(input wide_t v);
    q16_t r;
    if (v > SAT_MAX) begin
      r = 32'sh7fffffff;
    end else if (v < SAT_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [32:0] mag33(input q16_t v);
    logic [32:0] ext;
    ext = {v[31], v};
    return v[31] ? (33'd0 - ext) : ext;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/ghp_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gyro heading PID channels
// Command, result and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ghp_cmd_if;
  import ghp_pkg::*;
  logic  valid;
  logic  ready;
  func_t func;
  rate_t raw_rate;
  q16_t  angle;
  modport source (output valid, func, raw_rate, angle, input ready);
  modport sink   (input valid, func, raw_rate, angle, output ready);
endinterface

interface ghp_res_if;
  import ghp_pkg::*;
  logic  valid;
  logic  ready;
  q16_t  heading;
  rate_t rate;
  q16_t  drive;
  logic  drive_valid;
  modport source (output valid, heading, rate, drive, drive_valid, input ready);
  modport sink   (input valid, heading, rate, drive, drive_valid, output ready);
endinterface

interface ghp_cfg_if;
  import ghp_pkg::*;
  logic        valid;
  logic        ready;
  reg_idx_t    index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

### hw/rtl/gyro_heading_pid_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gyro heading PID core
// Heading integration from gyro rate words, heading set, and turn and hold control steps.
//
// Channels: cmd carries one command word (func, raw_rate, angle); res returns
// exactly one result word (heading, rate, drive, drive_valid) per command;
// cfg writes one register per word and is always ready.
// A command word is captured in an input register, evaluated
// combinationally against the tracker state, and lands in the result
// register. One word per cycle is sustained while res is ready; the
// combinational state update (average, multiply, saturate) bounds it.
// When res is stalled, the input register keeps one more word and cmd.ready
// drops once both registers are full; nothing is lost or reordered.
// Reset clears the tracker state, empties both registers and loads the
// register defaults (control disabled).
// ----------------------------------------------------------------------------
module gyro_heading_pid_core (
  input  wire       clk,
  input  wire       rst,
  ghp_cmd_if.sink   cmd,
  ghp_res_if.source res,
  ghp_cfg_if.sink   cfg
);
  import ghp_pkg::*;

  cfg_regs_t regs;

  logic  in_valid;
  func_t in_func;
  rate_t in_raw;
  q16_t  in_angle;

  rate_t filtered_rate;
  q16_t  heading_acc;
  q16_t  error_sum;
  q16_t  previous_error;

  rate_t filtered_rate_next;
  q16_t  heading_acc_next;
  q16_t  error_sum_next;
  q16_t  previous_error_next;
  q16_t  drive_next;
  logic  drive_valid_next;

  logic  out_valid;
  q16_t  out_heading;
  rate_t out_rate;
  q16_t  out_drive;
  logic  out_drive_valid;

  logic  advance;

  assign advance   = in_valid && (!out_valid || res.ready);
  assign cmd.ready = !in_valid || advance;
  assign cfg.ready = 1'b1;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.enable        <= 1'b0;
      regs.angle_gain    <= ANGLE_GAIN_RST;
      regs.gain_p        <= GAIN_P_RST;
      regs.gain_i        <= GAIN_I_RST;
      regs.gain_d        <= GAIN_D_RST;
      regs.turn_limit    <= TURN_LIMIT_RST;
      regs.windup_limit  <= WINDUP_LIMIT_RST;
      regs.hold_deadband <= HOLD_DEADBAND_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_ENABLE:        regs.enable        <= cfg.data[0];
        REG_ANGLE_GAIN:    regs.angle_gain    <= cfg.data;
        REG_GAIN_P:        regs.gain_p        <= cfg.data[GAIN_W-1:0];
        REG_GAIN_I:        regs.gain_i        <= cfg.data[GAIN_W-1:0];
        REG_GAIN_D:        regs.gain_d        <= cfg.data[GAIN_W-1:0];
        REG_TURN_LIMIT:    regs.turn_limit    <= cfg.data[LIM_W-1:0];
        REG_WINDUP_LIMIT:  regs.windup_limit  <= cfg.data[LIM_W-1:0];
        REG_HOLD_DEADBAND: regs.hold_deadband <= cfg.data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.ready) begin
      in_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      in_func  <= cmd.func;
      in_raw   <= cmd.raw_rate;
      in_angle <= cmd.angle;
    end
  end

  // single-pass update
  always_comb begin
    logic signed [16:0] rate_sum;
    logic signed [16:0] rate_half;
    logic signed [48:0] rate_prod;
    logic signed [48:0] rate_bias;
    logic signed [32:0] delta;
    q16_t               hdg_sample;
    q16_t               err;
    logic [32:0]        err_mag;
    logic signed [40:0] p_prod;
    logic signed [40:0] i_prod;
    logic signed [40:0] d_prod;
    q16_t               p_term;
    q16_t               i_term;
    q16_t               d_term;
    q16_t               diff;
    q16_t               es_acc;
    logic               windup_ok;
    q16_t               turn_sum;
    q16_t               lim;
    q16_t               es_int;

    rate_sum  = 17'(in_raw) + 17'(filtered_rate);
    rate_half = (rate_sum + (rate_sum[16] ? 17'sd1 : 17'sd0)) >>> 1;
    rate_prod = $signed(rate_half[15:0]) * $signed({1'b0, regs.angle_gain});
    rate_bias = rate_prod + (rate_prod[48] ? 49'sd65535 : 49'sd0);
    delta     = 33'(rate_bias >>> 16);
    hdg_sample = sat32(wide_t'(heading_acc) - wide_t'(delta));

    if (in_func == FUNC_TURN) begin
      err = sat32(wide_t'(in_angle) - wide_t'(heading_acc));
    end else begin
      err = sat32(-wide_t'(heading_acc));
    end
    err_mag = mag33(err);

    p_prod = err * $signed({1'b0, regs.gain_p});
    p_term = sat32(wide_t'(p_prod));

    diff   = sat32(wide_t'(err) - wide_t'(previous_error));
    d_prod = diff * $signed({1'b0, regs.gain_d});
    d_term = sat32(wide_t'(d_prod));

    windup_ok = mag33(error_sum) < {2'b00, regs.windup_limit};
    es_acc    = sat32(wide_t'(error_sum) + wide_t'(err));
    i_prod    = es_acc * $signed({1'b0, regs.gain_i});
    i_term    = windup_ok ? sat32(wide_t'(i_prod)) : '0;
    es_int    = windup_ok ? es_acc : error_sum;

    lim      = $signed({1'b0, regs.turn_limit});
    turn_sum = sat32(wide_t'(p_term) + wide_t'(i_term));

    filtered_rate_next  = filtered_rate;
    heading_acc_next    = heading_acc;
    error_sum_next      = error_sum;
    previous_error_next = previous_error;
    drive_next          = '0;
    drive_valid_next    = 1'b0;

    if (regs.enable) begin
      case (in_func)
        FUNC_SAMPLE: begin
          filtered_rate_next = rate_half[15:0];
          heading_acc_next   = hdg_sample;
        end
        FUNC_SET: begin
          heading_acc_next = in_angle;
        end
        FUNC_TURN: begin
          drive_valid_next = 1'b1;
          if (err_mag >= ONE_DEGREE) begin
            error_sum_next = es_int;
            if (turn_sum > lim) begin
              drive_next = lim;
            end else if (turn_sum < -lim) begin
              drive_next = -lim;
            end else begin
              drive_next = turn_sum;
            end
          end else begin
            error_sum_next = '0;
          end
        end
        default: begin
          drive_valid_next    = 1'b1;
          previous_error_next = err;
          if (err_mag > {2'b00, regs.hold_deadband}) begin
            error_sum_next = es_int;
            drive_next = sat32(wide_t'(p_term) + wide_t'(i_term) + wide_t'(d_term));
          end else begin
            error_sum_next = '0;
          end
        end
      endcase
    end
  end

  // tracker state
  always_ff @(posedge clk) begin
    if (rst) begin
      filtered_rate  <= '0;
      heading_acc    <= '0;
      error_sum      <= '0;
      previous_error <= '0;
    end else if (advance) begin
      filtered_rate  <= filtered_rate_next;
      heading_acc    <= heading_acc_next;
      error_sum      <= error_sum_next;
      previous_error <= previous_error_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_heading     <= heading_acc_next;
      out_rate        <= filtered_rate_next;
      out_drive       <= drive_next;
      out_drive_valid <= drive_valid_next;
    end
  end

  assign res.valid       = out_valid;
  assign res.heading     = out_heading;
  assign res.rate        = out_rate;
  assign res.drive       = out_drive;
  assign res.drive_valid = out_drive_valid;

endmodule
`default_nettype wire
